[src/quadrature_encoder_position_unit_defines.svh]
// assertion macros for the quadrature encoder position unit
`ifndef QUADRATURE_ENCODER_POSITION_UNIT_DEFINES_SVH
`define QUADRATURE_ENCODER_POSITION_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define QEP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define QEP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/qep_pkg.sv]
// shared types, constants and the quadrature step table
package qep_pkg;

  localparam int unsigned DefPositionWidth = 32;
  localparam int unsigned RegWidth         = 32;
  localparam int unsigned ScaleWidth       = 11;
  localparam int unsigned PresetWidth      = 16;
  localparam int unsigned ProdWidth        = PresetWidth + ScaleWidth + 1;
  localparam int unsigned CfgIdxWidth      = 3;

  localparam logic signed [RegWidth-1:0] RstMinValue  = 32'sd0;
  localparam logic signed [RegWidth-1:0] RstMaxValue  = 32'sd1000;
  localparam logic [ScaleWidth-1:0]      RstStepScale = 11'd10;

  localparam logic ModePreset = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MIN_VALUE     = 3'd0,
    CFG_MAX_VALUE     = 3'd1,
    CFG_STEP_SCALE    = 3'd2,
    CFG_INVERT_OUTPUT = 3'd3,
    CFG_WRAP_MODE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                          mode;
    logic                          pin_a;
    logic                          pin_b;
    logic                          button_rise;
    logic                          clear_changed;
    logic                          clear_clicked;
    logic signed [PresetWidth-1:0] preset_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RegWidth-1:0] value;
    logic signed [RegWidth-1:0] position;
    logic                       value_changed;
    logic                       button_clicked;
  } out_item_t;

  typedef struct packed {
    logic signed [RegWidth-1:0] min_value;
    logic signed [RegWidth-1:0] max_value;
    logic [ScaleWidth-1:0]      step_scale;
    logic                       invert_output;
    logic                       wrap_mode;
  } cfg_t;

  // registered input item with its scaled preset
  typedef struct packed {
    in_item_t                    item;
    logic signed [ProdWidth-1:0] preset_scaled;
  } stage_t;

  // index is {previous pins, current pins}, pins are {b, a}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    unique case (idx)
      4'h1, 4'h7, 4'h8, 4'he: step = -2'sd1;
      4'h2, 4'h4, 4'hb, 4'hd: step = 2'sd1;
      default:                step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

[src/qep_cfg.sv]
// configuration register file
module qep_cfg import qep_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [RegWidth-1:0]    cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_VALUE:     cfg_d.min_value     = $signed(cfg_wdata_i);
        CFG_MAX_VALUE:     cfg_d.max_value     = $signed(cfg_wdata_i);
        CFG_STEP_SCALE:    cfg_d.step_scale    = cfg_wdata_i[ScaleWidth-1:0];
        CFG_INVERT_OUTPUT: cfg_d.invert_output = cfg_wdata_i[0];
        CFG_WRAP_MODE:     cfg_d.wrap_mode     = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value     <= RstMinValue;
      cfg_q.max_value     <= RstMaxValue;
      cfg_q.step_scale    <= RstStepScale;
      cfg_q.invert_output <= 1'b0;
      cfg_q.wrap_mode     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/qep_in_stage.sv]
// input register stage, scales the preset value on capture
module qep_in_stage import qep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  input  logic     pop_i,
  output logic     valid_o,
  output stage_t   stage_o
);

  logic   valid_d, valid_q;
  logic   load;
  stage_t stage_d, stage_q;

  assign in_stall_o = valid_q && !pop_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    stage_d.item          = in_item_i;
    stage_d.preset_scaled = ProdWidth'(in_item_i.preset_value)
                            * ProdWidth'($signed({1'b0, cfg_i.step_scale}));
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[src/qep_core.sv]
// position state update, bound rule and result register
module qep_core import qep_pkg::*; #(
  parameter int unsigned PositionWidth = DefPositionWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  input  stage_t    stage_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // wide enough for position plus step and for the register bounds
  localparam int unsigned CmpWidth = (PositionWidth + 2 > RegWidth + 2) ?
                                     PositionWidth + 2 : RegWidth + 2;

  logic [1:0]                     prev_pins_d, prev_pins_q;
  logic signed [PositionWidth-1:0] position_d, position_q;
  logic                           changed_d, changed_q;
  logic                           clicked_d, clicked_q;
  logic                           out_valid_d, out_valid_q;
  out_item_t                      out_d, out_q;

  in_item_t                       item;
  logic [1:0]                     cur_pins;
  logic signed [1:0]              step;
  logic signed [CmpWidth-1:0]     pos_ext, sum, cand, min_ext, max_ext, p_hi, p_lo;
  logic signed [CmpWidth-1:0]     new_ext;
  logic                           do_bound;
  logic signed [RegWidth-1:0]     pos_out;

  assign item     = stage_i.item;
  assign cur_pins = {item.pin_b, item.pin_a};
  assign step     = quad_step({prev_pins_q, cur_pins});
  assign pop_o    = valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    pos_ext  = CmpWidth'(position_q);
    min_ext  = CmpWidth'(cfg_i.min_value);
    max_ext  = CmpWidth'(cfg_i.max_value);
    sum      = pos_ext + CmpWidth'(step);
    cand     = (item.mode == ModePreset) ? CmpWidth'(stage_i.preset_scaled) : sum;
    do_bound = (item.mode == ModePreset) || (step != 2'sd0);

    // upper bound first, then lower bound on the adjusted value
    p_hi = cand;
    if (cand > max_ext) begin
      p_hi = cfg_i.wrap_mode ? min_ext : max_ext;
    end
    p_lo = p_hi;
    if (p_hi < min_ext) begin
      p_lo = cfg_i.wrap_mode ? max_ext : min_ext;
    end

    position_d  = do_bound ? p_lo[PositionWidth-1:0] : position_q;
    prev_pins_d = (item.mode == ModePreset) ? prev_pins_q : cur_pins;
    changed_d   = (changed_q && !item.clear_changed)
                  || ((item.mode != ModePreset) && (cur_pins != prev_pins_q));
    clicked_d   = (clicked_q && !item.clear_clicked) || item.button_rise;

    new_ext = CmpWidth'(position_d);
    pos_out = new_ext[RegWidth-1:0];

    out_d.position       = pos_out;
    out_d.value          = cfg_i.invert_output ? (cfg_i.max_value - pos_out) : pos_out;
    out_d.value_changed  = changed_d;
    out_d.button_clicked = clicked_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q <= '0;
      position_q  <= '0;
      changed_q   <= 1'b0;
      clicked_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        prev_pins_q <= prev_pins_d;
        position_q  <= position_d;
        changed_q   <= changed_d;
        clicked_q   <= clicked_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[src/quadrature_encoder_position_unit.sv]
// top level of the quadrature encoder position unit
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o    in_item_i (in_item_t)
//  out       output     out_valid_o / out_stall_i  out_item_o (out_item_t)
//  cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle sustained while the result side does not stall
// an accepted transaction passes the input register, then the update into the result register
// the position update is a step lookup, one add and two bound compares
// reset clears position, previous pins, both flags and restores the registers
// a stalled result holds while the input register can still take one transaction
`include "quadrature_encoder_position_unit_defines.svh"

module quadrature_encoder_position_unit import qep_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = DefPositionWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [RegWidth-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o
);

  // configuration registers; the user writes them only while no transaction is in flight, not enforced here
  cfg_t   cfg;

  // input register to core hookup
  logic   stage_valid;
  logic   stage_pop;
  stage_t stage;

  qep_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // captures the transaction and forms preset_value * step_scale
  qep_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .pop_i      (stage_pop),
    .valid_o    (stage_valid),
    .stage_o    (stage)
  );

  // updates position and flags, loads the result register
  qep_core #(
    .PositionWidth (POSITION_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (stage_valid),
    .stage_i     (stage),
    .pop_o       (stage_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // stall toward the input only when the input register is occupied
  `QEP_ASSERT_NOW(a_stall_needs_stage, in_stall_o, stage_valid, "stall with empty input register")

  // a held transaction moves to an empty result register at once
  `QEP_ASSERT_NEXT(a_stage_moves, stage_valid && !out_valid_o, out_valid_o, "stage did not advance")

  // a transaction blocked by a stalled result is not dropped
  `QEP_ASSERT_NEXT(a_stage_kept, stage_valid && out_valid_o && out_stall_i, stage_valid,
                   "blocked transaction lost")

endmodule

[verif/quadrature_encoder_position_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the quadrature encoder position unit
module quadrature_encoder_position_unit_test;
  import qep_pkg::*;

  // position tracker and result checker: mirrors the decoder state and
  // registers, predicts one report per accepted transaction
  class position_scoreboard;
    logic signed [RegWidth-1:0] min_v;
    logic signed [RegWidth-1:0] max_v;
    logic [ScaleWidth-1:0]      scale;
    logic                       invert;
    logic                       wrap;
    logic [1:0]                 last_pins;
    logic signed [RegWidth-1:0] pos;
    logic                       changed;
    logic                       clicked;
    int                         step_lut[16];
    out_item_t                  report_q[$];
    int                         errors;

    function new();
      min_v     = RstMinValue;
      max_v     = RstMaxValue;
      scale     = RstStepScale;
      invert    = 1'b0;
      wrap      = 1'b0;
      last_pins = 2'b00;
      pos       = '0;
      changed   = 1'b0;
      clicked   = 1'b0;
      errors    = 0;
      // index is {previous pins, current pins}, pins are {b, a}
      step_lut  = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
    endfunction

    function void write_reg(cfg_idx_e idx, logic [RegWidth-1:0] data);
      case (idx)
        CFG_MIN_VALUE:     min_v  = data;
        CFG_MAX_VALUE:     max_v  = data;
        CFG_STEP_SCALE:    scale  = data[ScaleWidth-1:0];
        CFG_INVERT_OUTPUT: invert = data[0];
        CFG_WRAP_MODE:     wrap   = data[0];
        default: ;
      endcase
    endfunction

    // upper bound first, then lower bound on the adjusted value
    function logic signed [RegWidth-1:0] bound(longint p);
      longint lo;
      longint hi;
      lo = min_v;
      hi = max_v;
      if (p > hi) p = wrap ? lo : hi;
      if (p < lo) p = wrap ? hi : lo;
      return p[RegWidth-1:0];
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    function void note_input(in_item_t it);
      logic [1:0] now_pins;
      longint     sum;
      longint     pv;
      longint     sc;
      int         d;
      out_item_t  r;
      now_pins = {it.pin_b, it.pin_a};
      if (it.clear_changed) changed = 1'b0;
      if (it.clear_clicked) clicked = 1'b0;
      if (it.mode == ModePreset) begin
        pv  = $signed(it.preset_value);
        sc  = scale;
        pos = bound(pv * sc);
      end else begin
        d = step_lut[{last_pins, now_pins}];
        if (d != 0) begin
          sum = pos;
          pos = bound(sum + d);
        end
        if (now_pins != last_pins) changed = 1'b1;
        last_pins = now_pins;
      end
      if (it.button_rise) clicked = 1'b1;
      r.value          = invert ? (max_v - pos) : pos;
      r.position       = pos;
      r.value_changed  = changed;
      r.button_clicked = clicked;
      report_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (report_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        errors++;
        return;
      end
      want = report_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
      if (got.value_changed !== want.value_changed) begin
        $error("value_changed: expected %0b, actual %0b",
               want.value_changed, got.value_changed);
        errors++;
      end
      if (got.button_clicked !== want.button_clicked) begin
        $error("button_clicked: expected %0b, actual %0b",
               want.button_clicked, got.button_clicked);
        errors++;
      end
    endfunction
  endclass

  // pin pairs {b, a} that visit all sixteen previous/current combinations
  localparam logic [33:0] WalkAllPairs =
    34'b00_00_01_01_10_10_11_11_00_10_00_11_01_11_10_01_00;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 140;
  localparam int LongHoldCycles = 150;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_idx;
  logic [RegWidth-1:0]    cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_item;

  position_scoreboard sb;

  // idle chance in percent for both sides, zero gives back-to-back traffic
  int idle_pct;
  // asks the receiver for one long hold-off
  bit hold_req;
  // quadrature walk: position on the gray ring and its direction
  int ring_pos;
  int walk_dir;

  quadrature_encoder_position_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog, far above the slowest legal run
  initial begin
    #6_000_000;
    $display("quadrature_encoder_position_unit_test: FAIL");
    $finish;
  end

  // gray ring in the +1 direction: 00 -> 10 -> 11 -> 01, pins are {b, a}
  function automatic logic [1:0] ring_pins(int idx);
    case (idx & 3)
      0:       return 2'b00;
      1:       return 2'b10;
      2:       return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // register settings per phase: small windows to hit the bounds often,
  // full range extremes, bounds near the integer limits, inverted bounds
  function automatic cfg_t phase_cfg(int phase);
    cfg_t c;
    case (phase)
      0:       c = '{-32'sd8, 32'sd8, 11'd3, 1'b0, 1'b0};
      1:       c = '{-32'sd8, 32'sd8, 11'd1, 1'b1, 1'b1};
      2:       c = '{32'h8000_0000, 32'h7fff_ffff, 11'd1024, 1'b1, 1'b0};
      3:       c = '{32'sd2147483640, 32'h7fff_ffff, 11'd2047, 1'b0, 1'b1};
      4:       c = '{32'h8000_0000, -32'sd2147483640, 11'd5, 1'b1, 1'b0};
      5:       c = '{32'sd5, -32'sd5, 11'd0, 1'b1, 1'b1};
      6:       c = '{-32'sd1000, 32'sd1000, 11'd1024, 1'b0, 1'b1};
      default: c = '{RstMinValue, RstMaxValue, RstStepScale, 1'b0, 1'b0};
    endcase
    return c;
  endfunction

  // mostly legal quadrature walks, some repeats, jumps and presets
  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    it               = '0;
    roll             = $urandom_range(0, 99);
    it.button_rise   = ($urandom_range(0, 99) < 15);
    it.clear_changed = ($urandom_range(0, 99) < 15);
    it.clear_clicked = ($urandom_range(0, 99) < 15);
    if (roll < 12) begin
      it.mode = ModePreset;
      {it.pin_b, it.pin_a} = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) it.preset_value = 16'($urandom());
      else it.preset_value = 16'($urandom_range(0, 40)) - 16'd20;
    end else begin
      it.mode = ~ModePreset;
      if (roll < 20) begin
        // noise: any pin pair, including double steps
        ring_pos = $urandom_range(0, 3);
      end else if (roll >= 27) begin
        if ($urandom_range(0, 9) == 0) walk_dir = -walk_dir;
        ring_pos = (ring_pos + walk_dir) & 3;
      end
      {it.pin_b, it.pin_a} = ring_pins(ring_pos);
      // preset field is ignored for samples, keep it toggling anyway
      it.preset_value = 16'($urandom());
    end
    return it;
  endfunction

  // offer one transaction, hold it until accepted, then maybe idle a burst
  task automatic send_item(in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted report has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // two-stage pipe, a few extra cycles are plenty
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [RegWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // narrow registers get random upper bits, which must be ignored
  task automatic write_regs(cfg_t c);
    put_reg(CFG_MIN_VALUE, c.min_value);
    put_reg(CFG_MAX_VALUE, c.max_value);
    put_reg(CFG_STEP_SCALE, ($urandom() << ScaleWidth) | c.step_scale);
    put_reg(CFG_INVERT_OUTPUT, ($urandom() << 1) | c.invert_output);
    put_reg(CFG_WRAP_MODE, ($urandom() << 1) | c.wrap_mode);
    cfg_we <= 1'b0;
  endtask

  // receiver: checks each accepted result, stalls in random bursts and
  // once for a long stretch so the block backs up into its input
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // sender: reset, directed transactions, then random phases
  initial begin
    in_item_t it;
    int       phase_idle[NumPhases];
    sb        = new();
    idle_pct  = 0;
    hold_req  = 1'b0;
    ring_pos  = 0;
    walk_dir  = 1;
    // last phase runs with no idling at all
    phase_idle = '{20, 35, 0, 15, 30, 0, 25, 0};
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_MIN_VALUE;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset register values
    idle_pct = 25;
    // every previous/current pin combination, with clears that coincide
    // with a pin change and a click clear that meets a new click
    for (int i = 0; i < 17; i++) begin
      it               = '0;
      it.mode          = ~ModePreset;
      {it.pin_b, it.pin_a} = WalkAllPairs[33-2*i -: 2];
      it.button_rise   = (i % 4 == 1);
      it.clear_changed = (i % 5 == 2);
      it.clear_clicked = (i % 4 == 1) || (i % 7 == 3);
      it.preset_value  = 16'($urandom());
      send_item(it);
    end
    // preset extremes, pins ignored, click counts in preset mode
    for (int i = 0; i < 4; i++) begin
      it               = '0;
      it.mode          = ModePreset;
      it.pin_a         = 1'b1;
      it.pin_b         = 1'b1;
      it.button_rise   = (i == 0);
      it.clear_changed = (i == 2);
      case (i)
        0:       it.preset_value = 16'sh7fff;
        1:       it.preset_value = 16'sh8000;
        2:       it.preset_value = -16'sd1;
        default: it.preset_value = 16'sd0;
      endcase
      send_item(it);
    end
    drain();
    // the walk resumes from the pins last seen by the block
    ring_pos = 0;

    for (int phase = 0; phase < NumPhases; phase++) begin
      write_regs(phase_cfg(phase));
      idle_pct = phase_idle[phase];
      for (int k = 0; k < PhaseItems; k++) begin
        // long receiver hold-off while the sender keeps offering
        if (phase == 1 && k == 30) hold_req = 1'b1;
        // sender pause until the pipe is empty, no register change
        if (phase == 3 && k == 70) drain();
        send_item(random_item());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("quadrature_encoder_position_unit_test: PASS");
    end else begin
      $display("quadrature_encoder_position_unit_test: FAIL");
    end
    $finish;
  end

endmodule
